// File: sv/box_filter_mean_top_macros.svh
// Assertion helpers shared by the filter modules.
`ifndef BOX_FILTER_MEAN_TOP_MACROS_SVH
`define BOX_FILTER_MEAN_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BFM_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BFM_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/bfm_pkg.sv
package bfm_pkg;

    localparam int DEF_MAX_WINDOW = 15;
    localparam int DEF_MAX_WIDTH  = 1024;

    localparam int WIN_W   = 4;
    localparam int FW_W    = 11;
    localparam int ROW_W   = 12;
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int S_W     = WIN_W - 1;
    localparam int N_W     = 2 * WIN_W;
    localparam int SUM_W   = 16;
    localparam int CIDX_W  = 4;
    localparam int CDAT_W  = ROW_W;
    localparam int FIFO_DEPTH = 2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [CIDX_W-1:0] {
        REG_WINDOW_SIZE  = 4'd0,
        REG_FRAME_WIDTH  = 4'd1,
        REG_FRAME_HEIGHT = 4'd2,
        REG_COLOR_MODE   = 4'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SUM,
        B_LAST,
        B_PREP,
        B_DIV,
        B_DONE
    } back_state_t;

    typedef struct packed {
        logic              filter_on;
        logic              color;
        logic [WIN_W-1:0]  win;
        logic [S_W-1:0]    half;
        logic [N_W-1:0]    area;
        logic [FW_W-1:0]   width;
        logic [ROW_W-1:0]  height;
    } filt_cfg_t;

endpackage

// File: sv/bfm_line_mem.sv
module bfm_line_mem
    import bfm_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH
)
(
    input  logic                                             clk,
    input  logic                                             we,
    input  logic [$clog2(MAX_WINDOW)+$clog2(MAX_WIDTH)-1:0]  waddr,
    input  logic [PIX_W-1:0]                                 wdata,
    input  logic                                             re,
    input  logic [$clog2(MAX_WINDOW)+$clog2(MAX_WIDTH)-1:0]  raddr,
    output logic [PIX_W-1:0]                                 rdata
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int DEPTH = MAX_WINDOW << CW;

    logic [PIX_W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/bfm_job_fifo.sv
`include "box_filter_mean_top_macros.svh"

module bfm_job_fifo
    import bfm_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty,
    output logic              full
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [DATA_W-1:0] slot_q [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(FIFO_DEPTH));
    assign pop_data = slot_q[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_q[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    `BFM_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !full, "job queue overflow")
    `BFM_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, !empty, "job queue underflow")

endmodule

// File: sv/bfm_front.sv
module bfm_front
    import bfm_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH
)
(
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             in_valid,
    output logic                                             in_stall,
    input  logic                                             op,
    input  logic [CH_W-1:0]                                  chan_a,
    input  logic [CH_W-1:0]                                  chan_b,
    input  logic [CH_W-1:0]                                  chan_c,
    input  logic                                             cfg_valid,
    output logic                                             cfg_ready,
    input  logic [CIDX_W-1:0]                                cfg_index,
    input  logic [CDAT_W-1:0]                                cfg_data,
    output logic                                             mem_we,
    output logic [$clog2(MAX_WINDOW)+$clog2(MAX_WIDTH)-1:0]  mem_waddr,
    output logic [PIX_W-1:0]                                 mem_wdata,
    output logic                                             push,
    output logic [ROW_W+$clog2(MAX_WIDTH)+$clog2(MAX_WINDOW):0] push_data,
    input  logic                                             fifo_full,
    input  logic                                             fifo_empty,
    input  logic                                             back_idle,
    output filt_cfg_t                                        cfg
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int SLW   = $clog2(MAX_WINDOW);
    localparam int WW    = CW + 1;
    localparam int IDX_W = ROW_W + CW;
    localparam int DLY_W = S_W + WW + 1;

    logic [WIN_W-1:0] win_reg;
    logic [FW_W-1:0]  fw_reg;
    logic [ROW_W-1:0] fh_reg;
    logic             color_reg;

    logic [ROW_W-1:0] in_row_reg;
    logic [CW-1:0]    in_col_reg;
    logic [SLW-1:0]   in_slot_reg;
    logic [IDX_W-1:0] in_idx_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [CW-1:0]    out_col_reg;
    logic [SLW-1:0]   out_slot_reg;
    logic [IDX_W-1:0] out_idx_reg;

    logic [WW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;
    logic             filter_on;
    logic [S_W-1:0]   half;
    logic [DLY_W-1:0] delay;
    logic             in_done;
    logic             acc;
    logic             pix_take;
    logic             drain_take;
    logic [WW-1:0]    in_col_inc;
    logic [WW-1:0]    out_col_inc;
    logic [IDX_W-1:0] in_idx_inc;
    logic             emit;
    logic             out_last;
    logic             cfg_hit;

    always_comb
    begin
        if (fw_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(fw_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(fw_reg);
        end
    end

    assign h_eff     = (fh_reg == '0) ? ROW_W'(1) : fh_reg;
    assign filter_on = win_reg[0] && (32'(win_reg) <= MAX_WINDOW);
    assign half      = win_reg[WIN_W-1:1];
    assign delay     = filter_on ? (DLY_W'(half) * DLY_W'(w_eff) + DLY_W'(half)) : '0;

    assign cfg.filter_on = filter_on;
    assign cfg.color     = color_reg;
    assign cfg.win       = win_reg;
    assign cfg.half      = half;
    assign cfg.area      = N_W'({4'b0, win_reg} * {4'b0, win_reg});
    assign cfg.width     = FW_W'(w_eff);
    assign cfg.height    = h_eff;

    // Pixels wait until the back end is quiet so no pending window gets overwritten.
    assign in_stall   = (op == OP_DRAIN) ? fifo_full : !(fifo_empty && back_idle);
    assign acc        = in_valid && !in_stall;
    assign in_done    = (in_row_reg >= h_eff);
    assign pix_take   = acc && (op == OP_PIXEL) && !in_done;
    assign drain_take = acc && (op == OP_DRAIN) && in_done;

    assign in_col_inc  = WW'(in_col_reg) + WW'(1);
    assign out_col_inc = WW'(out_col_reg) + WW'(1);
    assign in_idx_inc  = in_idx_reg + IDX_W'(1);

    assign emit     = (pix_take && ((in_idx_inc - out_idx_reg) > IDX_W'(delay))) || drain_take;
    assign out_last = (out_row_reg == h_eff - ROW_W'(1)) && (out_col_inc == w_eff);

    assign push      = emit;
    assign push_data = {out_row_reg, out_col_reg, out_slot_reg, out_last};

    assign mem_we    = pix_take;
    assign mem_waddr = {in_slot_reg, in_col_reg};
    assign mem_wdata = {chan_c, chan_b, chan_a};

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && ((cfg_index == REG_WINDOW_SIZE) ||
                                     (cfg_index == REG_FRAME_WIDTH) ||
                                     (cfg_index == REG_FRAME_HEIGHT) ||
                                     (cfg_index == REG_COLOR_MODE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= WIN_W'(3);
            fw_reg    <= FW_W'(640);
            fh_reg    <= ROW_W'(480);
            color_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WINDOW_SIZE:  win_reg   <= cfg_data[WIN_W-1:0];
                REG_FRAME_WIDTH:  fw_reg    <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: fh_reg    <= cfg_data[ROW_W-1:0];
                REG_COLOR_MODE:   color_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            in_idx_reg   <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
            out_idx_reg  <= '0;
        end
        else if (cfg_hit)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            in_idx_reg   <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
            out_idx_reg  <= '0;
        end
        else
        begin
            if (pix_take)
            begin
                in_idx_reg <= in_idx_inc;
                if (in_col_inc >= w_eff)
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= in_row_reg + ROW_W'(1);
                    in_slot_reg <= (in_slot_reg == SLW'(MAX_WINDOW - 1)) ? '0
                                                                         : in_slot_reg + SLW'(1);
                end
                else
                begin
                    in_col_reg <= in_col_inc[CW-1:0];
                end
            end
            if (emit)
            begin
                if (out_last)
                begin
                    // wrap to a new frame
                    in_row_reg   <= '0;
                    in_col_reg   <= '0;
                    in_slot_reg  <= '0;
                    in_idx_reg   <= '0;
                    out_row_reg  <= '0;
                    out_col_reg  <= '0;
                    out_slot_reg <= '0;
                    out_idx_reg  <= '0;
                end
                else
                begin
                    out_idx_reg <= out_idx_reg + IDX_W'(1);
                    if (out_col_inc >= w_eff)
                    begin
                        out_col_reg  <= '0;
                        out_row_reg  <= out_row_reg + ROW_W'(1);
                        out_slot_reg <= (out_slot_reg == SLW'(MAX_WINDOW - 1)) ? '0
                                                                    : out_slot_reg + SLW'(1);
                    end
                    else
                    begin
                        out_col_reg <= out_col_inc[CW-1:0];
                    end
                end
            end
        end
    end

endmodule

// File: sv/bfm_back.sv
`include "box_filter_mean_top_macros.svh"

module bfm_back
    import bfm_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH
)
(
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  filt_cfg_t                                        cfg,
    input  logic                                             fifo_empty,
    output logic                                             pop,
    input  logic [ROW_W+$clog2(MAX_WIDTH)+$clog2(MAX_WINDOW):0] pop_data,
    output logic                                             back_idle,
    output logic                                             mem_re,
    output logic [$clog2(MAX_WINDOW)+$clog2(MAX_WIDTH)-1:0]  mem_raddr,
    input  logic [PIX_W-1:0]                                 mem_rdata,
    output logic                                             out_valid,
    input  logic                                             out_stall,
    output logic [CH_W-1:0]                                  out_a,
    output logic [CH_W-1:0]                                  out_b,
    output logic [CH_W-1:0]                                  out_c,
    output logic                                             frame_end
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int SLW   = $clog2(MAX_WINDOW);
    localparam int TOK_W = ROW_W + CW + SLW + 1;
    localparam int CNT_W = $clog2(SUM_W);

    back_state_t state_reg;
    back_state_t state_next;

    logic [ROW_W-1:0] tok_row;
    logic [CW-1:0]    tok_col;
    logic [SLW-1:0]   tok_slot;
    logic             tok_last;
    logic             tok_interior;
    logic [CW-1:0]    start_col;
    logic [SLW-1:0]   start_slot;

    logic             last_reg;
    logic             interior_reg;
    logic [WIN_W-1:0] span_reg;
    logic [WIN_W-1:0] i_reg;
    logic [WIN_W-1:0] j_reg;
    logic [CW-1:0]    col_x_reg;
    logic [CW-1:0]    col_st_reg;
    logic [SLW-1:0]   slot_y_reg;
    logic             rd_vld_reg;
    logic [PIX_W-1:0] pix_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [2:0][SUM_W-1:0] sum_reg;
    logic [2:0][SUM_W-1:0] dvd_reg;
    logic [2:0][N_W-1:0]   rem_reg;

    logic             out_valid_reg;
    logic [CH_W-1:0]  out_a_reg;
    logic [CH_W-1:0]  out_b_reg;
    logic [CH_W-1:0]  out_c_reg;
    logic             frame_end_reg;

    logic             out_load;
    logic             win_end;

    function automatic logic [N_W+SUM_W-1:0] div_step(input logic [N_W-1:0]   rem,
                                                       input logic [SUM_W-1:0] dvd,
                                                       input logic [N_W-1:0]   den);
        logic [N_W:0] rem_sh;
        logic         ge;
        logic [N_W:0] diff;
        rem_sh = {rem, dvd[SUM_W-1]};
        ge     = (rem_sh >= {1'b0, den});
        diff   = rem_sh - {1'b0, den};
        return {ge ? diff[N_W-1:0] : rem_sh[N_W-1:0], dvd[SUM_W-2:0], ge};
    endfunction

    assign tok_last = pop_data[0];
    assign tok_slot = pop_data[SLW:1];
    assign tok_col  = pop_data[SLW+CW:SLW+1];
    assign tok_row  = pop_data[TOK_W-1:SLW+CW+1];

    assign tok_interior = cfg.filter_on &&
                          (32'(tok_row) >= 32'(cfg.half)) &&
                          (32'(tok_row) + 32'(cfg.half) < 32'(cfg.height)) &&
                          (32'(tok_col) >= 32'(cfg.half)) &&
                          (32'(tok_col) + 32'(cfg.half) < 32'(cfg.width));

    assign start_col = tok_interior ? (tok_col - CW'(cfg.half)) : tok_col;

    always_comb
    begin
        if (!tok_interior)
        begin
            start_slot = tok_slot;
        end
        else if (32'(tok_slot) >= 32'(cfg.half))
        begin
            start_slot = SLW'(32'(tok_slot) - 32'(cfg.half));
        end
        else
        begin
            start_slot = SLW'(32'(tok_slot) + MAX_WINDOW - 32'(cfg.half));
        end
    end

    assign win_end = (i_reg == span_reg - WIN_W'(1)) && (j_reg == span_reg - WIN_W'(1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!fifo_empty)
                begin
                    state_next = B_SUM;
                end
            end
            B_SUM:
            begin
                if (win_end)
                begin
                    state_next = B_LAST;
                end
            end
            B_LAST:
            begin
                state_next = interior_reg ? B_PREP : B_DONE;
            end
            B_PREP:
            begin
                state_next = B_DIV;
            end
            B_DIV:
            begin
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        mem_re    = 1'b0;
        out_load  = 1'b0;
        back_idle = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                back_idle = 1'b1;
                pop       = !fifo_empty;
            end
            B_SUM:
            begin
                mem_re = 1'b1;
            end
            B_DONE:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    assign mem_raddr = {slot_y_reg, col_x_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= mem_re;
        end
    end

    // window walk: columns inner, rows outer
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            last_reg     <= tok_last;
            interior_reg <= tok_interior;
            span_reg     <= tok_interior ? cfg.win : WIN_W'(1);
            i_reg        <= '0;
            j_reg        <= '0;
            col_x_reg    <= start_col;
            col_st_reg   <= start_col;
            slot_y_reg   <= start_slot;
        end
        else if (state_reg == B_SUM)
        begin
            if (i_reg == span_reg - WIN_W'(1))
            begin
                i_reg      <= '0;
                col_x_reg  <= col_st_reg;
                j_reg      <= j_reg + WIN_W'(1);
                slot_y_reg <= (slot_y_reg == SLW'(MAX_WINDOW - 1)) ? '0
                                                                   : slot_y_reg + SLW'(1);
            end
            else
            begin
                i_reg     <= i_reg + WIN_W'(1);
                col_x_reg <= col_x_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            sum_reg <= '0;
        end
        else if (rd_vld_reg)
        begin
            pix_reg <= mem_rdata;
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k] <= sum_reg[k] + SUM_W'(mem_rdata[k*CH_W +: CH_W]);
            end
        end
    end

    // restoring divide, one quotient bit per cycle on all three channels
    always_ff @(posedge clk)
    begin
        if (state_reg == B_PREP)
        begin
            cnt_reg <= '0;
            for (int k = 0; k < 3; k++)
            begin
                dvd_reg[k] <= sum_reg[k] + (cfg.color ? SUM_W'(cfg.area >> 1) : '0);
                rem_reg[k] <= '0;
            end
        end
        else if (state_reg == B_DIV)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            for (int k = 0; k < 3; k++)
            begin
                {rem_reg[k], dvd_reg[k]} <= div_step(rem_reg[k], dvd_reg[k], cfg.area);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            frame_end_reg <= last_reg;
            out_a_reg     <= interior_reg ? dvd_reg[0][CH_W-1:0] : pix_reg[CH_W-1:0];
            if (cfg.color)
            begin
                out_b_reg <= interior_reg ? dvd_reg[1][CH_W-1:0] : pix_reg[2*CH_W-1:CH_W];
                out_c_reg <= interior_reg ? dvd_reg[2][CH_W-1:0] : pix_reg[3*CH_W-1:2*CH_W];
            end
            else
            begin
                out_b_reg <= '0;
                out_c_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_a     = out_a_reg;
    assign out_b     = out_b_reg;
    assign out_c     = out_c_reg;
    assign frame_end = frame_end_reg;

    `BFM_ASSERT_NXT(a_sum_reads, clk, rst_n, state_reg == B_SUM, rd_vld_reg, "window read lost")
    `BFM_ASSERT_IMP(a_div_interior, clk, rst_n, state_reg == B_DIV, interior_reg,
                    "divide started for an edge pixel")
    `BFM_ASSERT_IMP(a_win_bound, clk, rst_n, state_reg == B_SUM,
                    (i_reg < span_reg) && (j_reg < span_reg), "window walk out of range")

endmodule

// File: sv/box_filter_mean_top.sv
// Streaming k-by-k box filter for raster-order gray or RGB pixels. A pixel request is
// written into the line store as it is taken, but it is only taken while the filter core
// has no work pending; drain requests can queue (two deep) behind a running output.
// Each interior output walks its window through the single read port of the line store,
// one pixel per cycle, then divides all three channel sums by the window area; an edge
// or pass-through pixel reads only its own pixel and skips the divide. The output
// register lets the next job run while a finished pixel waits for the downstream side.
module box_filter_mean_top
    import bfm_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              op,
    input  logic [CH_W-1:0]   chan_a,
    input  logic [CH_W-1:0]   chan_b,
    input  logic [CH_W-1:0]   chan_c,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CH_W-1:0]   out_a,
    output logic [CH_W-1:0]   out_b,
    output logic [CH_W-1:0]   out_c,
    output logic              frame_end,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CDAT_W-1:0] cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int SLW   = $clog2(MAX_WINDOW);
    localparam int TOK_W = ROW_W + CW + SLW + 1;

    filt_cfg_t          cfg;
    logic               mem_we;
    logic [SLW+CW-1:0]  mem_waddr;
    logic [PIX_W-1:0]   mem_wdata;
    logic               mem_re;
    logic [SLW+CW-1:0]  mem_raddr;
    logic [PIX_W-1:0]   mem_rdata;
    logic               push;
    logic [TOK_W-1:0]   push_data;
    logic               pop;
    logic [TOK_W-1:0]   pop_data;
    logic               fifo_empty;
    logic               fifo_full;
    logic               back_idle;

    bfm_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .chan_a     (chan_a),
        .chan_b     (chan_b),
        .chan_c     (chan_c),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .push       (push),
        .push_data  (push_data),
        .fifo_full  (fifo_full),
        .fifo_empty (fifo_empty),
        .back_idle  (back_idle),
        .cfg        (cfg)
    );

    bfm_job_fifo #(
        .DATA_W (TOK_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (fifo_empty),
        .full      (fifo_full)
    );

    bfm_line_mem #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bfm_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .pop_data   (pop_data),
        .back_idle  (back_idle),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_a      (out_a),
        .out_b      (out_b),
        .out_c      (out_c),
        .frame_end  (frame_end)
    );

endmodule

// File: dv/box_filter_mean_top_test.sv
module box_filter_mean_top_test;
    import bfm_pkg::*;

    localparam int LS_ROWS     = DEF_MAX_WINDOW;
    localparam int LS_COLS     = DEF_MAX_WIDTH;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE      = 400;
    localparam int ITEM_GOAL   = 700;

    typedef struct packed {
        logic [CH_W-1:0] a;
        logic [CH_W-1:0] b;
        logic [CH_W-1:0] c;
        logic            last;
    } pix_res_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              op;
    logic [CH_W-1:0]   chan_a;
    logic [CH_W-1:0]   chan_b;
    logic [CH_W-1:0]   chan_c;
    logic              out_valid;
    logic              out_stall;
    logic [CH_W-1:0]   out_a;
    logic [CH_W-1:0]   out_b;
    logic [CH_W-1:0]   out_c;
    logic              frame_end;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CIDX_W-1:0] cfg_index;
    logic [CDAT_W-1:0] cfg_data;

    box_filter_mean_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .chan_a    (chan_a),
        .chan_b    (chan_b),
        .chan_c    (chan_c),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_a     (out_a),
        .out_b     (out_b),
        .out_c     (out_c),
        .frame_end (frame_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // filter state mirror
    logic [PIX_W-1:0] rows_mem [LS_ROWS*LS_COLS];
    int unsigned      m_win, m_width, m_height, m_color;
    int unsigned      m_in_row, m_in_col, m_out_row, m_out_col;

    pix_res_t expected_px[$];
    int       n_err;
    int       n_sent;
    bit       no_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned eff_width();
        if (m_width == 0) return 1;
        if (m_width > LS_COLS) return LS_COLS;
        return m_width;
    endfunction

    function automatic int unsigned eff_height();
        return (m_height == 0) ? 1 : m_height;
    endfunction

    function automatic bit box_on();
        return (m_win % 2 == 1) && (m_win <= LS_ROWS);
    endfunction

    function automatic int unsigned mem_idx(int unsigned r, int unsigned c);
        return (r % LS_ROWS) * LS_COLS + (c % LS_COLS);
    endfunction

    function automatic void clear_pos();
        m_in_row = 0;
        m_in_col = 0;
        m_out_row = 0;
        m_out_col = 0;
    endfunction

    function automatic pix_res_t next_output();
        int unsigned  w, h, r, c, s, n, sa, sb, sc;
        logic [23:0]  px, v;
        pix_res_t     res;
        w = eff_width();
        h = eff_height();
        r = m_out_row;
        c = m_out_col;
        px = rows_mem[mem_idx(r, c)];
        res.a = px[7:0];
        res.b = px[15:8];
        res.c = px[23:16];
        if (box_on())
        begin
            s = m_win / 2;
            if (r >= s && r + s < h && c >= s && c + s < w)
            begin
                n = m_win * m_win;
                sa = 0;
                sb = 0;
                sc = 0;
                for (int unsigned y = r - s; y <= r + s; y++)
                    for (int unsigned x = c - s; x <= c + s; x++)
                    begin
                        v = rows_mem[mem_idx(y, x)];
                        sa += v[7:0];
                        sb += v[15:8];
                        sc += v[23:16];
                    end
                if (m_color != 0)
                begin
                    res.a = 8'((sa + n / 2) / n);
                    res.b = 8'((sb + n / 2) / n);
                    res.c = 8'((sc + n / 2) / n);
                end
                else
                    res.a = 8'(sa / n);
            end
        end
        if (m_color == 0)
        begin
            res.b = '0;
            res.c = '0;
        end
        res.last = (r + 1 == h) && (c + 1 == w);
        if (res.last)
            clear_pos();
        else
        begin
            m_out_col++;
            if (m_out_col >= w)
            begin
                m_out_col = 0;
                m_out_row++;
            end
        end
        return res;
    endfunction

    function automatic void predict_request(logic o, logic [7:0] a, logic [7:0] b,
                                            logic [7:0] c);
        int unsigned w, h, delay, s;
        w = eff_width();
        h = eff_height();
        if (o == OP_DRAIN)
        begin
            // drain before the frame is fully in: ignore
            if (m_in_row >= h)
                expected_px.push_back(next_output());
            return;
        end
        if (m_in_row >= h)
            return;
        rows_mem[mem_idx(m_in_row, m_in_col)] = {c, b, a};
        m_in_col++;
        if (m_in_col >= w)
        begin
            m_in_col = 0;
            m_in_row++;
        end
        delay = 0;
        if (box_on())
        begin
            s = m_win / 2;
            delay = s * w + s;
        end
        if ((m_in_row * w + m_in_col) - (m_out_row * w + m_out_col) > delay)
            expected_px.push_back(next_output());
    endfunction

    function automatic void apply_config(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] d);
        case (idx)
            REG_WINDOW_SIZE:  m_win = d[3:0];
            REG_FRAME_WIDTH:  m_width = d[10:0];
            REG_FRAME_HEIGHT: m_height = d[11:0];
            REG_COLOR_MODE:   m_color = d[0];
            default:          return;
        endcase
        clear_pos();
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(logic o, logic [7:0] a, logic [7:0] b, logic [7:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        chan_a <= a;
        chan_b <= b;
        chan_c <= c;
        do @(posedge clk); while (in_stall);
        n_sent++;
        predict_request(o, a, b, c);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_config(idx, d);
    endtask

    // hold off until every pending request has drained out of the block
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_px.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic setup(int k, int w, int h, int color);
        settle();
        write_reg(REG_WINDOW_SIZE, CDAT_W'(k));
        write_reg(REG_FRAME_WIDTH, CDAT_W'(w));
        write_reg(REG_FRAME_HEIGHT, CDAT_W'(h));
        write_reg(REG_COLOR_MODE, CDAT_W'(color));
    endtask

    function automatic logic [7:0] chan_value(int pattern);
        case (pattern)
            1:       return 8'hFF;
            2:       return 8'h00;
            3:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one full frame, then drains until the frame wraps
    task automatic run_frame(int pattern, bit noise, int pause_at);
        int total;
        total = eff_width() * eff_height();
        for (int i = 0; i < total; i++)
        begin
            if (i == pause_at)
            begin
                in_valid <= 1'b0;
                while (expected_px.size() != 0) @(posedge clk);
            end
            if (noise && $urandom_range(0, 19) == 0)
                send_item(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
            send_item(OP_PIXEL, chan_value(pattern), chan_value(pattern),
                      chan_value(pattern));
        end
        while (m_in_row >= eff_height())
        begin
            if (noise && $urandom_range(0, 9) == 0)
                send_item(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
            else
                send_item(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_defaults();
        for (int i = 0; i < 12; i++)
            send_item(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic test_directed();
        setup(1, 4, 3, 0);
        run_frame(0, 0, -1);
        setup(15, 15, 15, 1);
        run_frame(1, 0, -1);
        setup(2, 5, 4, 1);
        run_frame(0, 1, -1);
        setup(0, 3, 2, 1);
        run_frame(0, 0, -1);
        setup(3, 0, 4, 0);
        run_frame(0, 1, -1);
        // width above the line store, abandoned part way
        setup(1, 2047, 2, 1);
        for (int i = 0; i < 40; i++)
            send_item(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
        setup(1, 3, 0, 1);
        run_frame(2, 0, -1);
        setup(5, 3, 3, 1);
        run_frame(0, 1, -1);
        // unknown register index: no effect
        settle();
        write_reg(CIDX_W'(15), '1);
        write_reg(CIDX_W'(4), '0);
        run_frame(0, 1, -1);
        // tall frame, abandoned part way
        setup(3, 1, 4095, 0);
        for (int i = 0; i < 20; i++)
            send_item(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
        send_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_pause();
        setup(3, 6, 5, 1);
        run_frame(0, 0, 14);
    endtask

    task automatic test_random();
        int r, k, w, h;
        while (n_sent < ITEM_GOAL)
        begin
            r = $urandom_range(0, 99);
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            if (r < 70)
                k = 2 * $urandom_range(0, 3) + 1;
            else if (r < 74)
            begin
                k = 2 * $urandom_range(4, 5) + 1;
                w = $urandom_range(k, k + 2);
                h = $urandom_range(k, k + 1);
            end
            else if (r < 90)
                k = 2 * $urandom_range(0, 7);
            else
                k = $urandom_range(0, 15);
            no_idle = ($urandom_range(0, 4) == 0);
            setup(k, w, h, $urandom_range(0, 1));
            run_frame($urandom_range(0, 4) == 0 ? 3 : 0, $urandom_range(0, 3) == 0, -1);
        end
        no_idle = 1'b0;
    endtask

    always @(posedge clk)
    begin
        int run_left;
        bit hold;
        if (run_left == 0)
        begin
            hold = ($urandom_range(0, 2) == 0);
            run_left = pick_gap() + 1;
        end
        run_left--;
        out_stall <= no_idle ? 1'b0 : hold;
    end

    always @(posedge clk)
    begin
        pix_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_px.size() == 0)
            begin
                $error("unexpected output pixel a=%0d b=%0d c=%0d end=%0b",
                       out_a, out_b, out_c, frame_end);
                n_err++;
            end
            else
            begin
                want = expected_px.pop_front();
                if (out_a !== want.a)
                begin
                    $error("out_a: expected %0d, got %0d", want.a, out_a);
                    n_err++;
                end
                if (out_b !== want.b)
                begin
                    $error("out_b: expected %0d, got %0d", want.b, out_b);
                    n_err++;
                end
                if (out_c !== want.c)
                begin
                    $error("out_c: expected %0d, got %0d", want.c, out_c);
                    n_err++;
                end
                if (frame_end !== want.last)
                begin
                    $error("frame_end: expected %0b, got %0b", want.last, frame_end);
                    n_err++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        int quiet_cycles;
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_PIXEL;
        chan_a = '0;
        chan_b = '0;
        chan_c = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        n_err = 0;
        n_sent = 0;
        no_idle = 1'b0;
        m_win = 3;
        m_width = 640;
        m_height = 480;
        m_color = 0;
        clear_pos();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_directed();
        test_pause();
        test_random();

        settle();
        if (expected_px.size() != 0)
        begin
            $error("%0d output pixels never arrived", expected_px.size());
            n_err++;
        end
        if (n_err == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
